[src/asl_pkg.sv]
// Shared types, codes and helpers for the averaged sample logger.
package asl_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [2:0] log_op_t;
  typedef logic [1:0] cfg_idx_t;

  localparam kind_t KIND_TICK  = 3'd0;
  localparam kind_t KIND_CONV  = 3'd1;
  localparam kind_t KIND_READ  = 3'd2;
  localparam kind_t KIND_DROP  = 3'd3;
  localparam kind_t KIND_CLEAR = 3'd4;

  localparam log_op_t LOG_NOP   = 3'd0;
  localparam log_op_t LOG_READ  = 3'd1;
  localparam log_op_t LOG_DROP  = 3'd2;
  localparam log_op_t LOG_CLEAR = 3'd3;
  localparam log_op_t LOG_PUSH  = 3'd4;

  localparam cfg_idx_t CFG_PERIOD  = 2'd0;
  localparam cfg_idx_t CFG_SPACING = 2'd1;
  localparam cfg_idx_t CFG_SUBS    = 2'd2;
  localparam cfg_idx_t CFG_READS   = 2'd3;

  localparam int CNT_W     = 5;
  localparam int SUM_EXTRA = 4;
  localparam int CFG_DW    = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd16;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = 5'd1;
    end else if (v > COUNT_MAX) begin
      r = COUNT_MAX;
    end
    return r;
  endfunction

endpackage

[src/asl_div.sv]
// Shared restoring divider, one quotient bit per cycle, small divisor.
module asl_div import asl_pkg::*; #(
  parameter int SW = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SW-1:0]    dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SW-1:0]    quotient
);

  localparam int KW = $clog2(SW + 1);

  logic             busy_r, busy_nxt;
  logic [KW-1:0]    cnt_r, cnt_nxt;
  logic [SW-1:0]    dvd_r, dvd_nxt;
  logic [CNT_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-2:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] rem_sh;
  logic [CNT_W-1:0] rem_sub;

  assign rem_sh   = {rem_r, dvd_r[SW-1]};
  assign rem_sub  = rem_sh - dsr_r;
  assign done     = busy_r && (cnt_r == '0);
  assign quotient = dvd_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = KW'(SW);
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - KW'(1);
        if (rem_sh >= dsr_r) begin
          rem_nxt = rem_sub[CNT_W-2:0];
          dvd_nxt = {dvd_r[SW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[CNT_W-2:0];
          dvd_nxt = {dvd_r[SW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

endmodule

[src/asl_log.sv]
// Circular log memory with oldest pointer, entry count and registered read.
module asl_log import asl_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int VW    = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  log_op_t                      op,
  input  logic [$clog2(DEPTH)-1:0]     rd_index,
  input  logic [$clog2(DEPTH+1)-1:0]   drop,
  input  logic [VW-1:0]                push_value,
  input  logic [31:0]                  push_time,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  output logic                         rd_hit,
  output logic [VW-1:0]                rd_value,
  output logic [31:0]                  rd_time
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = VW + 32;
  localparam logic [IW:0] DEPTH_W = (IW + 1)'(DEPTH);

  logic [MW-1:0] mem [DEPTH];

  logic [IW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          hit_r;
  logic [MW-1:0] rd_data_r;

  logic          full;
  logic [IW-1:0] oldest_eff;
  logic [IW-1:0] count_eff;
  logic [IW-1:0] wr_slot;
  logic [IW-1:0] rd_slot;
  logic          wr_en;
  logic          rd_en;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[IW-1:0];
  endfunction

  assign full       = (count_r == CW'(DEPTH));
  assign oldest_eff = full ? wrap_add(oldest_r, IW'(1)) : oldest_r;
  assign count_eff  = full ? IW'(DEPTH - 1) : count_r[IW-1:0];
  assign wr_slot    = wrap_add(oldest_eff, count_eff);
  assign rd_slot    = wrap_add(oldest_r, rd_index);
  assign wr_en      = (op == LOG_PUSH);
  assign rd_en      = (op == LOG_READ);

  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    case (op)
      LOG_DROP: begin
        if ((drop == '0) || (drop >= count_r)) begin
          oldest_nxt = '0;
          count_nxt  = '0;
        end else begin
          oldest_nxt = wrap_add(oldest_r, drop[IW-1:0]);
          count_nxt  = count_r - drop;
        end
      end
      LOG_CLEAR: begin
        oldest_nxt = '0;
        count_nxt  = '0;
      end
      LOG_PUSH: begin
        oldest_nxt = oldest_eff;
        count_nxt  = CW'(count_eff) + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
      hit_r    <= 1'b0;
    end else begin
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      if (rd_en) begin
        hit_r <= (CW'(rd_index) < count_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= {push_time, push_value};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_slot];
    end
  end

  assign count    = count_r;
  assign rd_hit   = hit_r;
  assign rd_value = rd_data_r[VW-1:0];
  assign rd_time  = rd_data_r[MW-1:VW];

endmodule

[src/averaged_sample_logger_unit.sv]
// Averaged sample logger: tick timing, burst averaging and timestamped log.
//
// Input channel (in_valid/in_stall) carries one command per transfer: tick,
// ADC conversion, log read, drop oldest or clear. Every accepted item yields
// exactly one result transfer on the output channel (out_valid/out_stall).
// The configuration port writes one register per cycle; the user writes it only
// while idle, which the block itself does not enforce.
// Tick, read, drop, clear and non-final conversions go from transfer through
// the finish state to the result register. The conversion that closes a burst
// runs the shared divider, one quotient bit per cycle over ADC_BITS+4 bits,
// plus a second pass when it also closes a measurement. One item is handled
// at a time.
//
// Reset (synchronous, rst_n low) empties the log, zeroes the counters, idles
// the measurement and loads the register defaults. Log memory is not cleared.
// A result held by out_stall stays on the output; the next item is taken in
// the cycle the result register frees.
module averaged_sample_logger_unit import asl_pkg::*; #(
  parameter int LOG_DEPTH = 64,
  parameter int ADC_BITS  = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  cfg_idx_t                         cfg_index,
  input  logic [CFG_DW-1:0]                cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  kind_t                            in_kind,
  input  logic [ADC_BITS-1:0]              in_adc_value,
  input  logic [31:0]                      in_time_stamp,
  input  logic [$clog2(LOG_DEPTH)-1:0]     in_entry_index,
  input  logic [$clog2(LOG_DEPTH+1)-1:0]   in_drop_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_sample_request,
  output logic                             out_measure_ready,
  output logic [ADC_BITS-1:0]              out_measure_value,
  output logic [31:0]                      out_entry_time,
  output logic [ADC_BITS-1:0]              out_entry_value,
  output logic [$clog2(LOG_DEPTH+1)-1:0]   out_stored_count
);

  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam int AW = ADC_BITS;
  localparam int SW = ADC_BITS + SUM_EXTRA;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIVB = 2'd1;
  localparam logic [1:0] ST_DIVM = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [31:0]      period_r, spacing_r;
  logic [CNT_W-1:0] subs_cfg_r, reads_cfg_r;
  logic [31:0]      pe_r, pe_nxt;
  logic [31:0]      se_r, se_nxt;
  logic [CNT_W-1:0] sub_r, sub_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [SW-1:0]    bsum_r, bsum_nxt;
  logic [SW-1:0]    msum_r, msum_nxt;
  logic [31:0]      ltime_r, ltime_nxt;
  logic             req_r, req_nxt;
  logic             ready_r, ready_nxt;
  logic [AW-1:0]    mval_r, mval_nxt;
  logic             isrd_r, isrd_nxt;

  logic             ov_r;
  logic             o_req_r, o_ready_r;
  logic [AW-1:0]    o_mval_r, o_eval_r;
  logic [31:0]      o_etime_r;
  logic [CW-1:0]    o_cnt_r;

  logic             in_xfer;
  logic             load_out;

  logic             div_start;
  logic [SW-1:0]    div_dividend;
  logic [CNT_W-1:0] div_divisor;
  logic             div_done;
  logic [SW-1:0]    div_quot;

  log_op_t          log_op;
  logic [CW-1:0]    log_count;
  logic             log_hit;
  logic [AW-1:0]    log_value;
  logic [31:0]      log_time;

  logic [31:0]      pe_inc, se_inc;
  logic [SW-1:0]    bs, ms;
  logic [CNT_W-1:0] sub_n;
  logic             req_v;

  assign in_stall = (state_r != ST_IDLE) || (ov_r && out_stall);
  assign in_xfer  = in_valid && !in_stall;
  assign load_out = (state_r == ST_FIN);

  assign pe_inc = (pe_r == '1) ? pe_r : pe_r + 32'd1;
  assign se_inc = (se_r == '1) ? se_r : se_r + 32'd1;
  assign bs     = bsum_r + SW'(in_adc_value);
  assign ms     = msum_r + div_quot;
  assign sub_n  = sub_r + CNT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    pe_nxt       = pe_r;
    se_nxt       = se_r;
    sub_nxt      = sub_r;
    left_nxt     = left_r;
    bsum_nxt     = bsum_r;
    msum_nxt     = msum_r;
    ltime_nxt    = ltime_r;
    req_nxt      = req_r;
    ready_nxt    = ready_r;
    mval_nxt     = mval_r;
    isrd_nxt     = isrd_r;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = clamp_count(reads_cfg_r);
    log_op       = LOG_NOP;
    req_v        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_FIN;
          req_nxt   = 1'b0;
          ready_nxt = 1'b0;
          mval_nxt  = '0;
          isrd_nxt  = (in_kind == KIND_READ);
          case (in_kind)
            KIND_TICK: begin
              pe_nxt = pe_inc;
              se_nxt = se_inc;
              if (pe_inc > period_r) begin
                pe_nxt = '0;
                if (sub_r == '0) begin
                  sub_nxt  = CNT_W'(1);
                  msum_nxt = '0;
                  req_v    = 1'b1;
                end
              end
              if (!req_v && (sub_r != '0) && (left_r == '0) && (se_inc > spacing_r)) begin
                req_v = 1'b1;
              end
              if (req_v) begin
                left_nxt  = clamp_count(reads_cfg_r);
                bsum_nxt  = '0;
                se_nxt    = '0;
                ltime_nxt = in_time_stamp;
                req_nxt   = 1'b1;
              end
            end
            KIND_CONV: begin
              if ((sub_r != '0) && (left_r != '0)) begin
                bsum_nxt = bs;
                left_nxt = left_r - CNT_W'(1);
                if (left_r == CNT_W'(1)) begin
                  div_start    = 1'b1;
                  div_dividend = bs;
                  state_nxt    = ST_DIVB;
                end
              end
            end
            KIND_READ:  log_op = LOG_READ;
            KIND_DROP:  log_op = LOG_DROP;
            KIND_CLEAR: log_op = LOG_CLEAR;
            default: begin
            end
          endcase
        end
      end
      ST_DIVB: begin
        if (div_done) begin
          bsum_nxt  = '0;
          msum_nxt  = ms;
          sub_nxt   = sub_n;
          state_nxt = ST_FIN;
          if (sub_n > clamp_count(subs_cfg_r)) begin
            div_start    = 1'b1;
            div_dividend = ms;
            div_divisor  = clamp_count(subs_cfg_r);
            state_nxt    = ST_DIVM;
          end
        end
      end
      ST_DIVM: begin
        if (div_done) begin
          mval_nxt  = div_quot[AW-1:0];
          log_op    = LOG_PUSH;
          ready_nxt = 1'b1;
          sub_nxt   = '0;
          msum_nxt  = '0;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      period_r    <= 32'd60000;
      spacing_r   <= 32'd1000;
      subs_cfg_r  <= 5'd5;
      reads_cfg_r <= 5'd10;
      pe_r        <= '0;
      se_r        <= '0;
      sub_r       <= '0;
      left_r      <= '0;
      bsum_r      <= '0;
      msum_r      <= '0;
      ltime_r     <= '0;
      req_r       <= 1'b0;
      ready_r     <= 1'b0;
      mval_r      <= '0;
      isrd_r      <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pe_r    <= pe_nxt;
      se_r    <= se_nxt;
      sub_r   <= sub_nxt;
      left_r  <= left_nxt;
      bsum_r  <= bsum_nxt;
      msum_r  <= msum_nxt;
      ltime_r <= ltime_nxt;
      req_r   <= req_nxt;
      ready_r <= ready_nxt;
      mval_r  <= mval_nxt;
      isrd_r  <= isrd_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PERIOD:  period_r    <= cfg_wdata;
          CFG_SPACING: spacing_r   <= cfg_wdata;
          CFG_SUBS:    subs_cfg_r  <= cfg_wdata[CNT_W-1:0];
          CFG_READS:   reads_cfg_r <= cfg_wdata[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_req_r   <= req_r;
      o_ready_r <= ready_r;
      o_mval_r  <= mval_r;
      o_etime_r <= (isrd_r && log_hit) ? log_time : '0;
      o_eval_r  <= (isrd_r && log_hit) ? log_value : '0;
      o_cnt_r   <= log_count;
    end
  end

  asl_div #(
    .SW(SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  asl_log #(
    .DEPTH(LOG_DEPTH),
    .VW   (AW)
  ) u_log (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (log_op),
    .rd_index   (in_entry_index),
    .drop       (in_drop_count),
    .push_value (div_quot[AW-1:0]),
    .push_time  (ltime_r),
    .count      (log_count),
    .rd_hit     (log_hit),
    .rd_value   (log_value),
    .rd_time    (log_time)
  );

  assign out_valid          = ov_r;
  assign out_sample_request = o_req_r;
  assign out_measure_ready  = o_ready_r;
  assign out_measure_value  = o_mval_r;
  assign out_entry_time     = o_etime_r;
  assign out_entry_value    = o_eval_r;
  assign out_stored_count   = o_cnt_r;

endmodule

[src/asl_chk.sv]
// Port-level checker for the averaged sample logger, bound to the top level.
module asl_chk import asl_pkg::*; #(
  parameter int LOG_DEPTH = 64,
  parameter int ADC_BITS  = 10
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_sample_request,
  input logic                             out_measure_ready,
  input logic [ADC_BITS-1:0]              out_measure_value,
  input logic [$clog2(LOG_DEPTH+1)-1:0]   out_stored_count
);

  localparam int CW = $clog2(LOG_DEPTH + 1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stored_count <= CW'(LOG_DEPTH))
    else $error("stored count beyond log depth");

  a_req_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_sample_request && out_measure_ready))
    else $error("request and logged value on one result");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_measure_ready |-> out_measure_value == '0)
    else $error("measure value without new log entry");

endmodule

bind averaged_sample_logger_unit asl_chk #(
  .LOG_DEPTH(LOG_DEPTH),
  .ADC_BITS (ADC_BITS)
) u_asl_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_sample_request (out_sample_request),
  .out_measure_ready  (out_measure_ready),
  .out_measure_value  (out_measure_value),
  .out_stored_count   (out_stored_count)
);

[bench/tb.sv]
// Self-checking bench for averaged_sample_logger_unit: scripted and random command traffic.
module tb;
  import asl_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam kind_t KIND_SPARE_LO = 3'd5;
  localparam kind_t KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    kind_t       kind;
    logic [9:0]  adc;
    logic [31:0] ts;
    logic [5:0]  idx;
    logic [6:0]  drop;
  } cmd_t;

  typedef struct packed {
    logic        req;
    logic        ready;
    logic [9:0]  mval;
    logic [31:0] etime;
    logic [9:0]  evalue;
    logic [6:0]  count;
  } report_t;

  typedef struct {
    bit          is_reg;
    cfg_idx_t    reg_idx;
    logic [31:0] reg_val;
    cmd_t        c;
    bit          typed;
    report_t     want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  cfg_idx_t    cfg_index = CFG_PERIOD;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  kind_t       in_kind = KIND_TICK;
  logic [9:0]  in_adc_value = '0;
  logic [31:0] in_time_stamp = '0;
  logic [5:0]  in_entry_index = '0;
  logic [6:0]  in_drop_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_sample_request;
  logic        out_measure_ready;
  logic [9:0]  out_measure_value;
  logic [31:0] out_entry_time;
  logic [9:0]  out_entry_value;
  logic [6:0]  out_stored_count;

  averaged_sample_logger_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_adc_value(in_adc_value), .in_time_stamp(in_time_stamp),
    .in_entry_index(in_entry_index), .in_drop_count(in_drop_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_request(out_sample_request), .out_measure_ready(out_measure_ready),
    .out_measure_value(out_measure_value), .out_entry_time(out_entry_time),
    .out_entry_value(out_entry_value), .out_stored_count(out_stored_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // logger shadow: registers and state
  logic [31:0] cfg_period = 32'd60000;
  logic [31:0] cfg_spacing = 32'd1000;
  logic [4:0]  cfg_subs = 5'd5;
  logic [4:0]  cfg_reads = 5'd10;
  logic [9:0]  log_val [DEPTH];
  logic [31:0] log_ts [DEPTH];
  logic [5:0]  head = '0;
  logic [6:0]  fill = '0;
  logic [31:0] since_start = '0;
  logic [31:0] since_burst = '0;
  logic [4:0]  sub_no = '0;
  logic [4:0]  reads_owed = '0;
  logic [13:0] burst_acc = '0;
  logic [13:0] measure_acc = '0;
  logic [31:0] burst_ts = '0;

  report_t     awaited_reports[$];
  script_row_t script[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          drive_calm = 1'b0;
  bit          sink_calm = 1'b0;
  int          hold_left = 0;

  function automatic logic [4:0] bounded_count(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'd16) return 5'd16;
    return v;
  endfunction

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic start_burst(input logic [31:0] ts);
    reads_owed = bounded_count(cfg_reads);
    burst_acc = '0;
    since_burst = '0;
    burst_ts = ts;
  endtask

  task automatic advance_logger(input cmd_t c, output report_t r);
    logic [5:0] slot;
    r = '0;
    case (c.kind)
      KIND_TICK: begin
        if (since_start != '1) since_start++;
        if (since_burst != '1) since_burst++;
        if (since_start > cfg_period) begin
          since_start = '0;
          if (sub_no == 5'd0) begin
            sub_no = 5'd1;
            measure_acc = '0;
            start_burst(c.ts);
            r.req = 1'b1;
          end
        end
        if (!r.req && sub_no != 5'd0 && reads_owed == 5'd0 && since_burst > cfg_spacing) begin
          start_burst(c.ts);
          r.req = 1'b1;
        end
      end
      KIND_CONV: begin
        if (sub_no != 5'd0 && reads_owed != 5'd0) begin
          burst_acc = burst_acc + 14'(c.adc);
          reads_owed--;
          if (reads_owed == 5'd0) begin
            measure_acc = measure_acc + burst_acc / 14'(bounded_count(cfg_reads));
            burst_acc = '0;
            sub_no++;
            if (sub_no > bounded_count(cfg_subs)) begin
              r.mval = 10'(measure_acc / 14'(bounded_count(cfg_subs)));
              if (fill >= DEPTH) begin
                head++;
                fill = 7'(DEPTH - 1);
              end
              slot = head + fill[5:0];
              log_val[slot] = r.mval;
              log_ts[slot] = burst_ts;
              fill++;
              r.ready = 1'b1;
              sub_no = '0;
              measure_acc = '0;
            end
          end
        end
      end
      KIND_READ: begin
        if (7'(c.idx) < fill) begin
          slot = head + c.idx;
          r.etime = log_ts[slot];
          r.evalue = log_val[slot];
        end
      end
      KIND_DROP: begin
        if (c.drop == 7'd0 || c.drop >= fill) begin
          fill = '0;
          head = '0;
        end else begin
          head = head + c.drop[5:0];
          fill = fill - c.drop;
        end
      end
      KIND_CLEAR: begin
        fill = '0;
        head = '0;
      end
      default: ;
    endcase
    r.count = fill;
  endtask

  function automatic cmd_t random_cmd(input bit keep_log);
    cmd_t c;
    int roll;
    c.adc = 10'($urandom_range(0, 1023));
    c.ts = $urandom();
    c.idx = 6'((fill != 0 && $urandom_range(0, 1)) ? $urandom_range(0, fill - 1)
                                                   : $urandom_range(0, 63));
    c.drop = 7'((fill > 1 && $urandom_range(0, 1)) ? $urandom_range(1, fill - 1)
                                                   : $urandom_range(0, 64));
    roll = $urandom_range(0, 99);
    if (sub_no != 0 && reads_owed != 0 && roll < 85) begin
      c.kind = KIND_CONV;
      return c;
    end
    roll = $urandom_range(0, 99);
    if (roll < (keep_log ? 75 : 55)) c.kind = KIND_TICK;
    else if (roll < 80) c.kind = KIND_CONV;
    else if (roll < 90) c.kind = KIND_READ;
    else if (roll < 94) c.kind = keep_log ? KIND_READ : KIND_DROP;
    else if (roll < 97) c.kind = keep_log ? KIND_TICK : KIND_CLEAR;
    else c.kind = kind_t'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    return c;
  endfunction

  // called just after a rising edge; returns at the edge of the transfer
  task automatic send_item(input cmd_t c, input bit typed, input report_t want);
    int gap;
    report_t got;
    gap = draw_wait(drive_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= c.kind;
    in_adc_value <= c.adc;
    in_time_stamp <= c.ts;
    in_entry_index <= c.idx;
    in_drop_count <= c.drop;
    do @(posedge clk); while (!(in_valid && !in_stall));
    advance_logger(c, got);
    awaited_reports.push_back(typed ? want : got);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t i, input logic [31:0] v);
    drain();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= i;
    cfg_wdata <= v;
    case (i)
      CFG_PERIOD:  cfg_period = v;
      CFG_SPACING: cfg_spacing = v;
      CFG_SUBS:    cfg_subs = v[4:0];
      CFG_READS:   cfg_reads = v[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic add_op(input kind_t k, input logic [9:0] adc, input logic [31:0] ts,
                        input logic [5:0] idx, input logic [6:0] drop,
                        input bit typed, input report_t want);
    script_row_t row;
    row.is_reg = 1'b0;
    row.reg_idx = CFG_PERIOD;
    row.reg_val = '0;
    row.c = '{k, adc, ts, idx, drop};
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endtask

  task automatic add_reg(input cfg_idx_t i, input logic [31:0] v);
    script_row_t row;
    row.is_reg = 1'b1;
    row.reg_idx = i;
    row.reg_val = v;
    row.c = '0;
    row.typed = 1'b0;
    row.want = '0;
    script.push_back(row);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) hold_left = draw_wait(sink_calm);
      else if (hold_left > 0) hold_left--;
      out_stall <= (hold_left != 0);
    end
  end

  always @(posedge clk) begin
    report_t seen, want;
    bit bad;
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_sample_request, out_measure_ready, out_measure_value,
              out_entry_time, out_entry_value, out_stored_count};
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: got %p", seen);
      end else begin
        want = awaited_reports.pop_front();
        bad = (seen.req !== want.req) || (seen.ready !== want.ready) ||
              (seen.mval !== want.mval) || (seen.etime !== want.etime) ||
              (seen.evalue !== want.evalue) || (seen.count !== want.count);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d", cycles);
            $display("  expected req=%0d rdy=%0d mval=%0d etime=%h eval=%0d cnt=%0d",
                     want.req, want.ready, want.mval, want.etime, want.evalue, want.count);
            $display("  actual   req=%0d rdy=%0d mval=%0d etime=%h eval=%0d cnt=%0d",
                     seen.req, seen.ready, seen.mval, seen.etime, seen.evalue, seen.count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    script_row_t row;
    logic [31:0] per, spc, subs, rds;
    int n;
    bit keep;

    // reset defaults: nothing can start
    add_op(KIND_READ, 10'd0, 32'd0, 6'd0, 7'd0, 1'b1, '0);
    add_op(KIND_CONV, 10'd1023, 32'd0, 6'd0, 7'd0, 1'b1, '0);
    add_op(KIND_DROP, 10'd0, 32'd0, 6'd0, 7'd0, 1'b1, '0);
    add_op(KIND_CLEAR, 10'd0, 32'd0, 6'd0, 7'd0, 1'b1, '0);
    add_op(KIND_SPARE_LO, 10'd1023, 32'hFFFF_FFFF, 6'd63, 7'd64, 1'b1, '0);
    add_op(KIND_SPARE_HI, 10'd0, 32'd0, 6'd0, 7'd0, 1'b1, '0);
    add_op(KIND_READ, 10'd0, 32'd0, 6'd63, 7'd0, 1'b1, '0);
    add_op(KIND_TICK, 10'd0, 32'd0, 6'd0, 7'd0, 1'b1, '0);
    add_reg(CFG_PERIOD, 32'd1);
    add_reg(CFG_SPACING, 32'd1);
    add_reg(CFG_SUBS, 32'd2);
    add_reg(CFG_READS, 32'd2);
    // second tick exceeds a period of one: immediate request
    add_op(KIND_TICK, 10'd0, 32'hFFFF_FFFF, 6'd0, 7'd0, 1'b1,
           report_t'{1'b1, 1'b0, 10'd0, 32'd0, 10'd0, 7'd0});
    // spacing and period both run out mid-burst
    add_op(KIND_TICK, 10'd0, 32'd5, 6'd0, 7'd0, 1'b0, '0);
    add_op(KIND_TICK, 10'd0, 32'd6, 6'd0, 7'd0, 1'b0, '0);
    add_op(KIND_CONV, 10'd1023, 32'd0, 6'd0, 7'd0, 1'b0, '0);
    add_op(KIND_CONV, 10'd1022, 32'd0, 6'd0, 7'd0, 1'b0, '0);
    add_op(KIND_TICK, 10'd0, 32'd7, 6'd0, 7'd0, 1'b0, '0);
    add_op(KIND_CONV, 10'd0, 32'd0, 6'd0, 7'd0, 1'b0, '0);
    add_op(KIND_CONV, 10'd1, 32'd0, 6'd0, 7'd0, 1'b0, '0);
    add_op(KIND_READ, 10'd0, 32'd0, 6'd0, 7'd0, 1'b0, '0);
    // zero counts behave as one
    add_reg(CFG_SUBS, 32'd0);
    add_reg(CFG_READS, 32'd0);
    add_op(KIND_TICK, 10'd0, 32'h8000_0000, 6'd0, 7'd0, 1'b0, '0);
    add_op(KIND_TICK, 10'd0, 32'h7FFF_FFFF, 6'd0, 7'd0, 1'b0, '0);
    add_op(KIND_CONV, 10'd512, 32'd0, 6'd0, 7'd0, 1'b0, '0);
    add_reg(CFG_READS, 32'd2);
    add_op(KIND_TICK, 10'd0, 32'h1234_5678, 6'd0, 7'd0, 1'b0, '0);
    add_op(KIND_TICK, 10'd0, 32'hA5A5_A5A5, 6'd0, 7'd0, 1'b0, '0);
    // divisor changes while a burst is open
    add_reg(CFG_READS, 32'd3);
    add_op(KIND_CONV, 10'd900, 32'd0, 6'd0, 7'd0, 1'b0, '0);
    add_op(KIND_CONV, 10'd901, 32'd0, 6'd0, 7'd0, 1'b0, '0);
    add_op(KIND_DROP, 10'd0, 32'd0, 6'd0, 7'd64, 1'b0, '0);
    add_op(KIND_READ, 10'd0, 32'd0, 6'd0, 7'd0, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      row = script[i];
      if (row.is_reg) write_reg(row.reg_idx, row.reg_val);
      else send_item(row.c, row.typed, row.want);
    end

    for (int p = 0; p < 12; p++) begin
      keep = 1'b0;
      case (p)
        0: begin per = 1; spc = 1; subs = 1; rds = 1; n = 300; keep = 1'b1; end
        1: begin per = 4; spc = 2; subs = 2; rds = 3; n = 100; end
        2: begin per = 1; spc = 1; subs = 0; rds = 0; n = 60; end
        3: begin per = 2; spc = 1; subs = 31; rds = 1; n = 120; end
        4: begin per = 3; spc = 1; subs = 2; rds = 31; n = 100; end
        5: begin per = 1; spc = 1; subs = 16; rds = 16; n = 80; end
        6: begin per = 32'hFFFF_FFFF; spc = 32'hFFFF_FFFF; subs = 3; rds = 2; n = 40; end
        7: begin per = 2; spc = 32'hFFFF_FFFF; subs = 1; rds = 4; n = 60; end
        default: begin
          per = $urandom_range(1, 40);
          spc = $urandom_range(1, 8);
          subs = $urandom_range(1, 5);
          rds = $urandom_range(1, 5);
          n = 50;
        end
      endcase
      write_reg(CFG_PERIOD, per);
      write_reg(CFG_SPACING, spc);
      write_reg(CFG_SUBS, subs);
      write_reg(CFG_READS, rds);
      repeat (n) send_item(random_cmd(keep), 1'b0, '0);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
src/asl_pkg.sv
src/asl_div.sv
src/asl_log.sv
src/averaged_sample_logger_unit.sv
src/asl_chk.sv
bench/tb.sv
